// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define TFD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// condition must never be seen out of reset
`define TFD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);

`else

`define TFD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define TFD_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

// ----- rtl/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// shared types and constants of the telemetry frame deframer
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam logic [7:0] SYNC_VALUE = 8'hBB;
  localparam logic [7:0] MIN_LENGTH = 8'd20;
  localparam int         NUM_WORDS  = 5;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_SYNC2   = 3'd1,
    CMD_PLAIN   = 3'd2,
    CMD_LE      = 3'd3,
    CMD_BE      = 3'd4,
    CMD_LEN_BAD = 3'd5,
    CMD_SUM     = 3'd6
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [2:0]  widx;
    logic [1:0]  lane;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_emit(cmd_kind_t k);
    is_emit = (k == CMD_LEN_BAD) || (k == CMD_SUM);
  endfunction

endpackage

// ----- rtl/tfd_if.sv -----
// ----------------------------------------------------------------------------
// tfd_if
// byte input channel and frame result channel
// ----------------------------------------------------------------------------
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;

  modport source (output valid, output rx_byte, output first_byte, input ready);
  modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] roll_bits;
  logic [31:0] pitch_bits;
  logic [31:0] yaw_bits;
  logic [31:0] altitude;
  logic [31:0] battery;

  modport source (output valid, output status, output roll_bits, output pitch_bits,
                  output yaw_bits, output altitude, output battery, input ready);
  modport sink   (input valid, input status, input roll_bits, input pitch_bits,
                  input yaw_bits, input altitude, input battery, output ready);
endinterface

// ----- rtl/telemetry_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_core
// parses sync/length/sum telemetry frames from a byte stream
// ----------------------------------------------------------------------------
// Takes one datagram byte per clock cycle with no gaps of its own; in_ch.ready
// drops only when the two-entry command queue is full, which happens when the
// result register is held by out_ch.ready. A byte is classified in the cycle
// it is accepted, written into the command queue and executed when popped from
// the queue head; popping a sum or length byte loads the result register, which
// drives out_ch.valid and the result fields. One result per frame at most;
// datagrams that end early give none.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module telemetry_frame_deframer_core
  import tfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  tfd_in_if.sink    in_ch,
  tfd_out_if.source out_ch
);

  logic    q_push;
  logic    q_pop;
  cmd_t    q_wr_cmd;
  cmd_t    q_head;
  q_stat_t q_stat;

  tfd_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (q_push),
    .cmd    (q_wr_cmd)
  );

  tfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  tfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `TFD_ASSERT(a_start_forwarded, clk, rst_n,
    in_ch.valid && in_ch.ready && in_ch.first_byte |-> q_push, "start byte not queued")
  `TFD_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_stat.empty, "pop from empty queue")
  `TFD_ASSERT(a_stall_holds_emit, clk, rst_n,
    out_ch.valid && !out_ch.ready && is_emit(q_head.kind) |-> !q_pop,
    "result dropped while output stalled")
  `TFD_ASSERT_NEVER(a_no_push_full, clk, rst_n, q_push && q_stat.full, "push into full queue")

endmodule

// ----- rtl/tfd_front.sv -----
// ----------------------------------------------------------------------------
// tfd_front
// tracks byte position and frame length, classifies each byte into a command
// ----------------------------------------------------------------------------
module tfd_front
  import tfd_pkg::*;
#(
  parameter int BUFFER_BYTES = 128
) (
  input  logic    clk,
  input  logic    rst_n,
  tfd_in_if.sink  in_ch,
  input  q_stat_t q_stat,
  output logic    push,
  output cmd_t    cmd
);

  localparam int         PW         = $clog2(BUFFER_BYTES);
  localparam logic [8:0] MAX_LENGTH = 9'(BUFFER_BYTES - 6);

  logic          in_frame_r, in_frame_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    len_r, len_nxt;

  logic          accept;
  logic          active;
  logic [PW-1:0] pos_eff;
  logic [PW-1:0] off4;
  logic [PW-1:0] off16;
  logic [8:0]    sum_pos;
  logic [7:0]    b;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign active      = in_ch.first_byte || in_frame_r;
  assign pos_eff     = in_ch.first_byte ? '0 : pos_r;
  assign off4        = pos_eff - PW'(4);
  assign off16       = pos_eff - PW'(16);
  assign sum_pos     = {1'b0, len_r} + 9'd4;
  assign push        = accept && active;

  always_comb begin
    cmd.kind = CMD_PLAIN;
    cmd.data = b;
    cmd.widx = '0;
    cmd.lane = '0;
    if (in_ch.first_byte) begin
      cmd.kind = CMD_START;
    end else if (pos_eff == PW'(1)) begin
      cmd.kind = CMD_SYNC2;
    end else if (pos_eff == PW'(3)) begin
      if (b < MIN_LENGTH || {1'b0, b} > MAX_LENGTH) begin
        cmd.kind = CMD_LEN_BAD;
      end
    end else if (pos_eff >= PW'(4) && 9'(pos_eff) == sum_pos) begin
      cmd.kind = CMD_SUM;
    end else if (pos_eff >= PW'(4) && pos_eff < PW'(16)) begin
      cmd.kind = CMD_LE;
      cmd.widx = {1'b0, off4[3:2]};
      cmd.lane = off4[1:0];
    end else if (pos_eff >= PW'(16) && pos_eff < PW'(24)) begin
      cmd.kind = CMD_BE;
      cmd.widx = 3'd3 + {2'b0, off16[2]};
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    if (push) begin
      if (is_emit(cmd.kind)) begin
        in_frame_nxt = 1'b0;
      end else begin
        in_frame_nxt = 1'b1;
        pos_nxt      = pos_eff + PW'(1);
        if (in_ch.first_byte) begin
          len_nxt = '0;
        end else if (pos_eff == PW'(3)) begin
          len_nxt = b;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      len_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

// ----- rtl/tfd_queue.sv -----
// ----------------------------------------------------------------------------
// tfd_queue
// two-entry command queue between classifier and executor
// ----------------------------------------------------------------------------
module tfd_queue
  import tfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign head         = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/tfd_back.sv -----
// ----------------------------------------------------------------------------
// tfd_back
// executes commands: running sum, sync check, word assembly, result register
// ----------------------------------------------------------------------------
module tfd_back
  import tfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  tfd_out_if.source out_ch
);

  logic [7:0]  sum_r, sum_nxt;
  logic        sync_ok_r, sync_ok_nxt;
  logic [31:0] words_r [NUM_WORDS];
  logic [31:0] words_nxt [NUM_WORDS];
  logic        out_valid_r, out_valid_nxt;
  status_t     status_r;
  logic [31:0] fields_r [NUM_WORDS];

  logic        emit;
  logic        can_load;
  status_t     status_new;
  logic [31:0] le_word;

  assign emit     = is_emit(head.kind);
  assign can_load = !out_valid_r || out_ch.ready;
  assign pop      = !q_stat.empty && (!emit || can_load);
  assign le_word  = {24'b0, head.data} << {head.lane, 3'b0};

  always_comb begin
    if (head.kind == CMD_LEN_BAD) begin
      status_new = sync_ok_r ? ST_BAD_LEN : ST_BAD_SYNC;
    end else if (!sync_ok_r) begin
      status_new = ST_BAD_SYNC;
    end else if (sum_r != head.data) begin
      status_new = ST_BAD_SUM;
    end else begin
      status_new = ST_GOOD;
    end
  end

  always_comb begin
    sum_nxt     = sum_r;
    sync_ok_nxt = sync_ok_r;
    words_nxt   = words_r;
    if (pop) begin
      unique case (head.kind) inside
        CMD_START: begin
          sum_nxt     = head.data;
          sync_ok_nxt = (head.data == SYNC_VALUE);
          for (int i = 0; i < NUM_WORDS; i++) begin
            words_nxt[i] = '0;
          end
        end
        CMD_SYNC2: begin
          sum_nxt     = sum_r + head.data;
          sync_ok_nxt = sync_ok_r && (head.data == SYNC_VALUE);
        end
        CMD_LE: begin
          sum_nxt = sum_r + head.data;
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (head.widx == 3'(i)) begin
              words_nxt[i] = words_r[i] | le_word;
            end
          end
        end
        CMD_BE: begin
          sum_nxt = sum_r + head.data;
          for (int i = 0; i < NUM_WORDS; i++) begin
            if (head.widx == 3'(i)) begin
              words_nxt[i] = {words_r[i][23:0], head.data};
            end
          end
        end
        CMD_PLAIN: begin
          sum_nxt = sum_r + head.data;
        end
        CMD_LEN_BAD, CMD_SUM: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sync_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      sync_ok_r   <= sync_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r <= words_nxt;
    if (pop && emit) begin
      status_r <= status_new;
      for (int i = 0; i < NUM_WORDS; i++) begin
        fields_r[i] <= (status_new == ST_GOOD) ? words_r[i] : '0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.roll_bits  = fields_r[0];
  assign out_ch.pitch_bits = fields_r[1];
  assign out_ch.yaw_bits   = fields_r[2];
  assign out_ch.altitude   = fields_r[3];
  assign out_ch.battery    = fields_r[4];

endmodule

// ----- verif/tb_telemetry_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// tb_telemetry_frame_deframer_core
// self-checking bench for the sync/length/sum telemetry frame deframer
// ----------------------------------------------------------------------------
// A table of datagrams covers the corners first: bytes outside a frame, both
// length limits and lengths beyond them, bad sync bytes, bad sums, short
// datagrams, trailing bytes and all-zero/all-one payloads. Random datagrams
// follow, mostly well formed, with corrupt, cut and loose bytes mixed in.
// Each accepted byte runs through a behavioral parser that queues the
// expected frame result; results leaving the block are checked field by
// field in order. Both channels idle at random, and the result side holds off
// once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_telemetry_frame_deframer_core;
  import tfd_pkg::*;

  localparam int BUFFER_BYTES = 128;
  localparam int MAX_LEN      = BUFFER_BYTES - 6;
  localparam int ITEMS        = 1600;
  localparam int MIN_FRAMES   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] roll;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] altitude;
    logic [31:0] battery;
  } frame_result_t;

  typedef struct {
    logic [7:0] sync0;
    logic [7:0] sync1;
    logic [7:0] len;
    int         lead;
    int         cut;
    int         extra;
    int         fill;
    bit         sum_err;
    bit         typed;
    status_t    want;
  } dgram_row_t;

  logic clk;
  logic rst_n;

  tfd_in_if  in_ch ();
  tfd_out_if out_ch ();

  telemetry_frame_deframer_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // parser state
  logic [6:0]  fp_pos;
  logic [7:0]  fp_len;
  logic [7:0]  fp_sum;
  logic        fp_sync;
  logic        fp_in;
  logic [31:0] fp_w [NUM_WORDS];

  frame_result_t pending_frames[$];
  frame_result_t typed_frame;
  bit            typed_armed;

  bit in_idle_en;
  bit out_idle_en;
  bit hold_phase;
  bit hold_done;
  int hold_left;
  int mismatches;
  int parsed_bytes;
  int sent_bytes;
  int frames_predicted;
  int status_tally [4];
  int quiet_cycles;

  dgram_row_t frame_rows [15];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void frame_parse(input logic [7:0] b, input logic f, output bit used,
                                      output bit produced, output frame_result_t r);
    int p;
    int k;
    used = 1'b0;
    produced = 1'b0;
    r = '0;
    if (f) begin
      fp_pos  = '0;
      fp_len  = '0;
      fp_sum  = '0;
      foreach (fp_w[j]) fp_w[j] = '0;
      fp_in   = 1'b1;
      fp_sync = 1'b1;
    end
    if (!fp_in) return;
    used = 1'b1;
    p = int'(fp_pos);
    if (p < 2 && b != SYNC_VALUE) fp_sync = 1'b0;
    if (p == 3) begin
      fp_len = b;
      if (b < MIN_LENGTH || int'(b) > MAX_LEN) begin
        r.status = fp_sync ? ST_BAD_LEN : ST_BAD_SYNC;
        produced = 1'b1;
        fp_in = 1'b0;
        return;
      end
    end
    if (p >= 4 && p == int'(fp_len) + 4) begin
      if (!fp_sync) r.status = ST_BAD_SYNC;
      else if (fp_sum != b) r.status = ST_BAD_SUM;
      else begin
        r.status   = ST_GOOD;
        r.roll     = fp_w[0];
        r.pitch    = fp_w[1];
        r.yaw      = fp_w[2];
        r.altitude = fp_w[3];
        r.battery  = fp_w[4];
      end
      produced = 1'b1;
      fp_in = 1'b0;
      return;
    end
    if (p >= 4 && p < 16) begin
      k = (p - 4) >> 2;
      fp_w[k] = fp_w[k] | (32'(b) << (((p - 4) & 3) * 8));
    end else if (p >= 16 && p < 24) begin
      k = 3 + ((p - 16) >> 2);
      fp_w[k] = {fp_w[k][23:0], b};
    end
    fp_sum = fp_sum + b;
    fp_pos = 7'(p + 1);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  task automatic check_frame();
    frame_result_t want;
    if (pending_frames.size() == 0) begin
      report_mismatch("unexpected result, status", 32'(out_ch.status), 32'h0);
      return;
    end
    want = pending_frames.pop_front();
    status_tally[want.status]++;
    if (out_ch.status !== want.status)
      report_mismatch("status", 32'(out_ch.status), 32'(want.status));
    if (out_ch.roll_bits !== want.roll) report_mismatch("roll", out_ch.roll_bits, want.roll);
    if (out_ch.pitch_bits !== want.pitch)
      report_mismatch("pitch", out_ch.pitch_bits, want.pitch);
    if (out_ch.yaw_bits !== want.yaw) report_mismatch("yaw", out_ch.yaw_bits, want.yaw);
    if (out_ch.altitude !== want.altitude)
      report_mismatch("altitude", out_ch.altitude, want.altitude);
    if (out_ch.battery !== want.battery)
      report_mismatch("battery", out_ch.battery, want.battery);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic f);
    bit used;
    bit produced;
    frame_result_t r;
    int gap;
    gap = 0;
    while (in_idle_en && $urandom_range(0, 99) < 20) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.first_byte <= f;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent_bytes++;
    frame_parse(b, f, used, produced, r);
    if (used) parsed_bytes++;
    if (produced) begin
      frames_predicted++;
      if (typed_armed) begin
        pending_frames.push_back(typed_frame);
        typed_armed = 1'b0;
      end else begin
        pending_frames.push_back(r);
      end
    end
  endtask

  task automatic send_dgram(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] ln,
                            input int cut, input int extra, input int fill,
                            input bit sum_err);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int body;
    bit len_ok;
    len_ok = (ln >= MIN_LENGTH) && (int'(ln) <= MAX_LEN);
    fb.push_back(s0);
    fb.push_back(s1);
    fb.push_back(8'($urandom));
    fb.push_back(ln);
    body = len_ok ? int'(ln) : $urandom_range(0, 6);
    repeat (body) fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    if (len_ok) begin
      sum = '0;
      foreach (fb[i]) sum = sum + fb[i];
      if (sum_err) sum = sum + 8'($urandom_range(1, 255));
      fb.push_back(sum);
    end
    repeat (extra) fb.push_back(8'($urandom));
    if (cut > 0 && cut < fb.size()) fb = fb[0:cut-1];
    foreach (fb[i]) send_byte(fb[i], i == 0);
  endtask

  task automatic run_row(input dgram_row_t row);
    logic [31:0] word;
    word = (row.want == ST_GOOD) ? {4{row.fill[7:0]}} : 32'h0;
    if (row.typed) begin
      typed_frame = '{row.want, word, word, word, word, word};
      typed_armed = 1'b1;
    end
    repeat (row.lead) send_byte(8'($urandom), 1'b0);
    send_dgram(row.sync0, row.sync1, row.len, row.cut, row.extra, row.fill, row.sum_err);
    typed_armed = 1'b0;
  endtask

  function automatic logic [7:0] random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(20, 40));
    if (r < 95) return 8'($urandom_range(MIN_LENGTH, MAX_LEN));
    return 8'(MAX_LEN);
  endfunction

  task automatic send_random_dgram();
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] ln;
    int pick;
    int extra;
    s0 = SYNC_VALUE;
    s1 = SYNC_VALUE;
    ln = random_len();
    extra = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_dgram(s0, s1, ln, 0, extra, -1, 1'b0);
    end else if (pick < 65) begin
      send_dgram(s0, s1, ln, 0, extra, -1, 1'b1);
    end else if (pick < 73) begin
      case ($urandom_range(0, 2))
        0: s0 = 8'($urandom);
        1: s1 = 8'($urandom);
        default: begin
          s0 = 8'($urandom);
          s1 = 8'($urandom);
        end
      endcase
      send_dgram(s0, s1, ln, 0, extra, -1, 1'b0);
    end else if (pick < 82) begin
      ln = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_LENGTH - 1))
                                : 8'($urandom_range(MAX_LEN + 1, 255));
      if ($urandom_range(0, 99) < 30) s1 = 8'($urandom);
      send_dgram(s0, s1, ln, 0, extra, -1, 1'b0);
    end else if (pick < 92) begin
      send_dgram(s0, s1, ln, $urandom_range(1, int'(ln) + 4), 0, -1, 1'b0);
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
    end
  endtask

  // result side: random ready, one long hold-off when requested
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_frame();
      if (hold_phase && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(out_idle_en && $urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_frames.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = '0;
    in_ch.first_byte = 1'b0;
    out_ch.ready     = 1'b0;
    fp_pos  = '0;
    fp_len  = '0;
    fp_sum  = '0;
    fp_sync = 1'b0;
    fp_in   = 1'b0;
    foreach (fp_w[j]) fp_w[j] = '0;
    foreach (status_tally[j]) status_tally[j] = 0;
    typed_armed = 1'b0;
    hold_phase  = 1'b0;
    hold_done   = 1'b0;
    hold_left   = 0;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    mismatches  = 0;
    parsed_bytes = 0;
    sent_bytes   = 0;
    frames_predicted = 0;
    quiet_cycles = 0;

    // sync0, sync1, len, lead, cut, extra, fill, sum_err, typed, status
    frame_rows = '{
      '{SYNC_VALUE, SYNC_VALUE, 8'd20,  3, 0,  0, -1,    1'b0, 1'b0, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd20,  0, 0,  0, 'hFF,  1'b0, 1'b1, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd20,  0, 0,  0, 'h00,  1'b0, 1'b1, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd122, 0, 0,  0, -1,    1'b0, 1'b0, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd19,  0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_LEN},
      '{SYNC_VALUE, SYNC_VALUE, 8'd123, 0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_LEN},
      '{SYNC_VALUE, SYNC_VALUE, 8'd0,   0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_LEN},
      '{SYNC_VALUE, SYNC_VALUE, 8'd255, 0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_LEN},
      '{8'h00,      SYNC_VALUE, 8'd20,  0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_SYNC},
      '{SYNC_VALUE, 8'h44,      8'd5,   0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_SYNC},
      '{8'hFF,      8'hFF,      8'd122, 0, 0,  0, -1,    1'b0, 1'b1, ST_BAD_SYNC},
      '{SYNC_VALUE, SYNC_VALUE, 8'd20,  0, 0,  0, -1,    1'b1, 1'b1, ST_BAD_SUM},
      '{SYNC_VALUE, SYNC_VALUE, 8'd30,  0, 12, 0, -1,    1'b0, 1'b0, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd21,  0, 0,  3, -1,    1'b0, 1'b0, ST_GOOD},
      '{SYNC_VALUE, SYNC_VALUE, 8'd40,  0, 3,  0, -1,    1'b0, 1'b0, ST_GOOD}
    };

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (frame_rows[i]) run_row(frame_rows[i]);

    // long stretch with both sides streaming
    in_idle_en = 1'b0;
    out_idle_en <= 1'b0;
    while (parsed_bytes < ITEMS / 4) send_random_dgram();

    // back-pressure: hold the result side while short failing frames pile up
    in_idle_en = 1'b1;
    out_idle_en <= 1'b1;
    hold_phase <= 1'b1;
    repeat (8) send_dgram(SYNC_VALUE, SYNC_VALUE, 8'd5, 0, 0, -1, 1'b0);

    while (parsed_bytes < ITEMS || frames_predicted < MIN_FRAMES) send_random_dgram();
    in_ch.valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d parsed inside frames, %0d frame results",
             sent_bytes, parsed_bytes, frames_predicted);
    $display("results by status: good %0d, bad sync %0d, bad sum %0d, bad length %0d",
             status_tally[ST_GOOD], status_tally[ST_BAD_SYNC], status_tally[ST_BAD_SUM],
             status_tally[ST_BAD_LEN]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
